### design/rwlt_pkg.sv
package rwlt_pkg;

   // sizes of the fixed payload fields
   localparam int KIND_W  = 2;
   localparam int ID_W    = 4;
   localparam int OUT_W   = 2;
   localparam int COUNT_W = 5;
   localparam int MODE_W  = 2;

   // ids at or above this cannot be expressed on the request ports
   localparam int ID_LIMIT = 1 << ID_W;

   // default table sizes
   localparam int NUM_VARS_DEFAULT = 16;
   localparam int NUM_TXNS_DEFAULT = 16;

   // reader count saturation point
   localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_READ    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_UPGRADE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd3;

   // held modes
   localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

   // outcomes
   localparam logic [OUT_W-1:0] OUT_OK      = 2'd0;
   localparam logic [OUT_W-1:0] OUT_WAIT    = 2'd1;
   localparam logic [OUT_W-1:0] OUT_REFUSED = 2'd2;

   // result of one lock step: answer plus new entry state
   typedef struct packed {
      logic [OUT_W-1:0]   outcome;
      logic               wake;
      logic [COUNT_W-1:0] count;
      logic               wflag;
      logic               wwait;
      logic [MODE_W-1:0]  mode;
   } step_result_type;

endpackage

### design/rwlt_ram.sv
module rwlt_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port (read returns old data)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/rwlt_decide.sv
module rwlt_decide (
   input  logic [rwlt_pkg::KIND_W-1:0]  kind,
   input  logic                         in_range,
   input  logic [rwlt_pkg::MODE_W-1:0]  mode,
   input  logic [rwlt_pkg::COUNT_W-1:0] count,
   input  logic                         wflag,
   input  logic                         wwait,
   output rwlt_pkg::step_result_type    res
);

   logic [rwlt_pkg::COUNT_W-1:0] count_dec;

   // decrement that holds at zero
   assign count_dec = (count != '0) ? count - rwlt_pkg::COUNT_W'(1) : count;

   always_comb begin
      res.outcome = rwlt_pkg::OUT_OK;
      res.wake    = 1'b0;
      res.count   = count;
      res.wflag   = wflag;
      res.wwait   = wwait;
      res.mode    = mode;

      case (kind)
         // shared acquire
         rwlt_pkg::KIND_READ: begin
            if (mode != rwlt_pkg::MODE_NONE) begin
               res.outcome = rwlt_pkg::OUT_OK;
            end else if (wflag || count >= rwlt_pkg::COUNT_MAX) begin
               res.outcome = rwlt_pkg::OUT_WAIT;
            end else begin
               res.mode  = rwlt_pkg::MODE_READ;
               res.count = count + rwlt_pkg::COUNT_W'(1);
            end
         end
         // exclusive acquire
         rwlt_pkg::KIND_WRITE: begin
            if (mode == rwlt_pkg::MODE_WRITE) begin
               res.outcome = rwlt_pkg::OUT_OK;
            end else if (wflag || count != '0) begin
               res.outcome = rwlt_pkg::OUT_WAIT;
               res.wwait   = 1'b1;
            end else begin
               res.mode  = rwlt_pkg::MODE_WRITE;
               res.wflag = 1'b1;
            end
         end
         // read to write, sole reader only
         rwlt_pkg::KIND_UPGRADE: begin
            if (mode != rwlt_pkg::MODE_READ) begin
               res.outcome = rwlt_pkg::OUT_REFUSED;
            end else if (wflag || count > rwlt_pkg::COUNT_W'(1)) begin
               res.outcome = rwlt_pkg::OUT_WAIT;
               res.wwait   = 1'b1;
            end else begin
               res.mode  = rwlt_pkg::MODE_WRITE;
               res.count = count_dec;
               res.wflag = 1'b1;
            end
         end
         // release whatever is held
         rwlt_pkg::KIND_RELEASE: begin
            if (mode == rwlt_pkg::MODE_WRITE) begin
               res.mode  = rwlt_pkg::MODE_NONE;
               res.wflag = 1'b0;
               res.wake  = 1'b1;
               res.wwait = 1'b0;
            end else if (mode == rwlt_pkg::MODE_READ) begin
               res.mode  = rwlt_pkg::MODE_NONE;
               res.count = count_dec;
               if (count_dec == '0 && wwait) begin
                  res.wake  = 1'b1;
                  res.wwait = 1'b0;
               end
            end
         end
         default: begin
            res.outcome = rwlt_pkg::OUT_OK;
         end
      endcase

      // ids out of range answer refused with an empty view
      if (!in_range) begin
         res.outcome = rwlt_pkg::OUT_REFUSED;
         res.wake    = 1'b0;
         res.count   = '0;
         res.wflag   = 1'b0;
         res.wwait   = wwait;
         res.mode    = mode;
      end
   end

endmodule

### design/reader_writer_lock_table_unit.sv
// channel   direction  handshake          payload
// req       in         req_valid/stall    req_kind, req_txn_id, req_var_index
// rsp       out        rsp_valid/stall    rsp_outcome, rsp_wake_waiters,
//                                         rsp_readers_now, rsp_writer_held
//
// one request per cycle sustained while rsp_stall is low; accept loads the decide stage
// and the result register, with rsp_valid, loads from it; the rate is set by the single decide
// stage, which reads the held-mode RAM (registered read issued at accept) and writes it back as
// the result loads; reset clears per-variable state and held-mode valid bits
// rsp_stall holds a valid result register and, with the decide stage full, stalls req in the same cycle
module reader_writer_lock_table_unit #(
   parameter int NUM_VARS = rwlt_pkg::NUM_VARS_DEFAULT,
   parameter int NUM_TXNS = rwlt_pkg::NUM_TXNS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [rwlt_pkg::KIND_W-1:0]   req_kind,
   input  logic [rwlt_pkg::ID_W-1:0]     req_txn_id,
   input  logic [rwlt_pkg::ID_W-1:0]     req_var_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rwlt_pkg::OUT_W-1:0]    rsp_outcome,
   output logic                          rsp_wake_waiters,
   output logic [rwlt_pkg::COUNT_W-1:0]  rsp_readers_now,
   output logic                          rsp_writer_held
);

   // only ids reachable through the ports need storage
   localparam int VAR_USED = (NUM_VARS < rwlt_pkg::ID_LIMIT) ? NUM_VARS : rwlt_pkg::ID_LIMIT;
   localparam int TXN_USED = (NUM_TXNS < rwlt_pkg::ID_LIMIT) ? NUM_TXNS : rwlt_pkg::ID_LIMIT;
   localparam int DEPTH    = VAR_USED * TXN_USED;
   localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int VW       = (VAR_USED > 1) ? $clog2(VAR_USED) : 1;

   // decide stage registers
   logic                          stage_valid_ff;
   logic [rwlt_pkg::KIND_W-1:0]   kind_ff;
   logic [VW-1:0]                 var_ff;
   logic [AW-1:0]                 addr_ff;
   logic                          in_range_ff;
   logic                          byp_ff;
   logic [rwlt_pkg::MODE_W-1:0]   byp_mode_ff;

   // per-variable state and held-mode valid bits
   logic [rwlt_pkg::COUNT_W-1:0]  count_ff [VAR_USED];
   logic                          wflag_ff [VAR_USED];
   logic                          wwait_ff [VAR_USED];
   logic                          mode_valid_ff [DEPTH];

   // result register
   logic                          rsp_valid_ff;
   logic [rwlt_pkg::OUT_W-1:0]    outcome_ff;
   logic                          wake_ff;
   logic [rwlt_pkg::COUNT_W-1:0]  readers_ff;
   logic                          writer_ff;

   logic                          req_accept;
   logic                          advance;
   logic                          wr_en;
   logic                          in_range_in;
   logic [AW-1:0]                 addr_in;
   logic [VW-1:0]                 var_in;
   logic                          byp_in;
   logic [rwlt_pkg::MODE_W-1:0]   ram_rd;
   logic [rwlt_pkg::MODE_W-1:0]   mode_cur;
   rwlt_pkg::step_result_type     res;

   // handshake
   assign advance    = stage_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = stage_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign wr_en      = advance && in_range_ff;

   // request decode
   assign in_range_in = (32'(req_txn_id) < NUM_TXNS) && (32'(req_var_index) < NUM_VARS);
   assign addr_in     = AW'(32'(req_txn_id) * VAR_USED + 32'(req_var_index));
   assign var_in      = VW'(req_var_index);

   // the entry written this cycle is read stale by the ram, forward it
   assign byp_in = wr_en && (addr_in == addr_ff);

   rwlt_ram #(
      .WIDTH (rwlt_pkg::MODE_W),
      .DEPTH (DEPTH)
   ) u_mode_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (res.mode),
      .rd_en   (req_accept),
      .rd_addr (addr_in),
      .rd_data (ram_rd)
   );

   // held mode of the staged transaction
   always_comb begin
      if (byp_ff) begin
         mode_cur = byp_mode_ff;
      end else if (mode_valid_ff[addr_ff]) begin
         mode_cur = ram_rd;
      end else begin
         mode_cur = rwlt_pkg::MODE_NONE;
      end
   end

   rwlt_decide u_decide (
      .kind     (kind_ff),
      .in_range (in_range_ff),
      .mode     (mode_cur),
      .count    (count_ff[var_ff]),
      .wflag    (wflag_ff[var_ff]),
      .wwait    (wwait_ff[var_ff]),
      .res      (res)
   );

   // stage, state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < VAR_USED; i++) begin
            count_ff[i] <= '0;
            wflag_ff[i] <= 1'b0;
            wwait_ff[i] <= 1'b0;
         end
         for (int i = 0; i < DEPTH; i++) begin
            mode_valid_ff[i] <= 1'b0;
         end
      end else begin
         // load the decide stage
         if (req_accept) begin
            stage_valid_ff <= 1'b1;
            kind_ff        <= req_kind;
            var_ff         <= var_in;
            addr_ff        <= addr_in;
            in_range_ff    <= in_range_in;
            byp_ff         <= byp_in;
            byp_mode_ff    <= res.mode;
         end else if (advance) begin
            stage_valid_ff <= 1'b0;
         end

         // commit the lock update
         if (wr_en) begin
            count_ff[var_ff]      <= res.count;
            wflag_ff[var_ff]      <= res.wflag;
            wwait_ff[var_ff]      <= res.wwait;
            mode_valid_ff[addr_ff] <= 1'b1;
         end

         // result register
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            outcome_ff   <= res.outcome;
            wake_ff      <= res.wake;
            readers_ff   <= res.count;
            writer_ff    <= res.wflag;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_outcome      = outcome_ff;
   assign rsp_wake_waiters = wake_ff;
   assign rsp_readers_now  = readers_ff;
   assign rsp_writer_held  = writer_ff;

endmodule

### design/rwlt_checker.sv
module rwlt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [rwlt_pkg::OUT_W-1:0]    rsp_outcome,
   input logic                          rsp_wake_waiters,
   input logic [rwlt_pkg::COUNT_W-1:0]  rsp_readers_now,
   input logic                          rsp_writer_held
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_outcome)
         && $stable(rsp_readers_now))
      else $error("stalled result changed");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // a write lock never coexists with readers
   a_writer_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_writer_held |-> rsp_readers_now == '0)
      else $error("writer held with readers");

   // wakeups only come with a granted step and no writer held
   a_wake_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_wake_waiters |-> rsp_outcome == rwlt_pkg::OUT_OK
         && !rsp_writer_held)
      else $error("wake on a failed or locked step");

   // the input only stalls behind a held result
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with the result side free");

endmodule

bind reader_writer_lock_table_unit rwlt_checker u_rwlt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_outcome      (rsp_outcome),
   .rsp_wake_waiters (rsp_wake_waiters),
   .rsp_readers_now  (rsp_readers_now),
   .rsp_writer_held  (rsp_writer_held)
);

### dv/reader_writer_lock_table_unit_tb.sv
module reader_writer_lock_table_unit_tb;

   localparam int N_VARS     = rwlt_pkg::NUM_VARS_DEFAULT;
   localparam int N_TXNS     = rwlt_pkg::NUM_TXNS_DEFAULT;
   localparam int RAND_ITEMS = 1000;
   localparam int HOLD_LEN   = 60;

   typedef struct packed {
      logic [rwlt_pkg::KIND_W-1:0] kind;
      logic [rwlt_pkg::ID_W-1:0]   txn;
      logic [rwlt_pkg::ID_W-1:0]   vidx;
   } lock_req_type;

   typedef struct packed {
      logic [rwlt_pkg::OUT_W-1:0]   outcome;
      logic                         wake;
      logic [rwlt_pkg::COUNT_W-1:0] readers;
      logic                         writer;
   } lock_answer_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [rwlt_pkg::KIND_W-1:0]   req_kind = '0;
   logic [rwlt_pkg::ID_W-1:0]     req_txn_id = '0;
   logic [rwlt_pkg::ID_W-1:0]     req_var_index = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [rwlt_pkg::OUT_W-1:0]    rsp_outcome;
   logic                          rsp_wake_waiters;
   logic [rwlt_pkg::COUNT_W-1:0]  rsp_readers_now;
   logic                          rsp_writer_held;

   // shadow lock table
   logic [rwlt_pkg::COUNT_W-1:0]  shadow_readers [N_VARS];
   logic                          shadow_writer  [N_VARS];
   logic                          shadow_waiting [N_VARS];
   logic [rwlt_pkg::MODE_W-1:0]   shadow_mode    [N_TXNS*N_VARS];

   lock_req_type    pending_reqs[$];
   lock_answer_type lock_answers_q[$];

   int total_items = 0;
   int sent_count = 0;
   int error_count = 0;
   int n_checked = 0;
   int n_granted = 0;
   int n_waits = 0;
   int n_refused = 0;
   int n_wakes = 0;
   int peak_readers = 0;
   int hold_left = 0;
   int next_hold_at = 150;

   reader_writer_lock_table_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_txn_id       (req_txn_id),
      .req_var_index    (req_var_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_outcome      (rsp_outcome),
      .rsp_wake_waiters (rsp_wake_waiters),
      .rsp_readers_now  (rsp_readers_now),
      .rsp_writer_held  (rsp_writer_held)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // lock table step: updates the shadow table and returns the answer
   function automatic lock_answer_type apply_lock_request(lock_req_type r);
      lock_answer_type             a;
      int unsigned                 slot;
      logic [rwlt_pkg::MODE_W-1:0] mode;
      a.outcome = rwlt_pkg::OUT_OK;
      a.wake    = 1'b0;
      a.readers = '0;
      a.writer  = 1'b0;
      if (int'(r.txn) >= N_TXNS || int'(r.vidx) >= N_VARS) begin
         a.outcome = rwlt_pkg::OUT_REFUSED;
         return a;
      end
      slot = int'(r.txn) * N_VARS + int'(r.vidx);
      mode = shadow_mode[slot];
      case (r.kind)
         rwlt_pkg::KIND_READ: begin
            if (mode != rwlt_pkg::MODE_NONE) begin
               a.outcome = rwlt_pkg::OUT_OK;
            end else if (shadow_writer[r.vidx]
                         || shadow_readers[r.vidx] >= rwlt_pkg::COUNT_MAX) begin
               a.outcome = rwlt_pkg::OUT_WAIT;
            end else begin
               shadow_mode[slot] = rwlt_pkg::MODE_READ;
               shadow_readers[r.vidx] = shadow_readers[r.vidx] + 1'b1;
            end
         end
         rwlt_pkg::KIND_WRITE: begin
            if (mode == rwlt_pkg::MODE_WRITE) begin
               a.outcome = rwlt_pkg::OUT_OK;
            end else if (shadow_writer[r.vidx] || shadow_readers[r.vidx] != '0) begin
               a.outcome = rwlt_pkg::OUT_WAIT;
               shadow_waiting[r.vidx] = 1'b1;
            end else begin
               shadow_mode[slot] = rwlt_pkg::MODE_WRITE;
               shadow_writer[r.vidx] = 1'b1;
            end
         end
         rwlt_pkg::KIND_UPGRADE: begin
            if (mode != rwlt_pkg::MODE_READ) begin
               a.outcome = rwlt_pkg::OUT_REFUSED;
            end else if (shadow_writer[r.vidx] || shadow_readers[r.vidx] > 1) begin
               a.outcome = rwlt_pkg::OUT_WAIT;
               shadow_waiting[r.vidx] = 1'b1;
            end else begin
               shadow_mode[slot] = rwlt_pkg::MODE_WRITE;
               if (shadow_readers[r.vidx] != '0)
                  shadow_readers[r.vidx] = shadow_readers[r.vidx] - 1'b1;
               shadow_writer[r.vidx] = 1'b1;
            end
         end
         default: begin
            if (mode == rwlt_pkg::MODE_WRITE) begin
               shadow_mode[slot] = rwlt_pkg::MODE_NONE;
               shadow_writer[r.vidx] = 1'b0;
               a.wake = 1'b1;
            end else if (mode == rwlt_pkg::MODE_READ) begin
               shadow_mode[slot] = rwlt_pkg::MODE_NONE;
               if (shadow_readers[r.vidx] != '0)
                  shadow_readers[r.vidx] = shadow_readers[r.vidx] - 1'b1;
               if (shadow_readers[r.vidx] == '0 && shadow_waiting[r.vidx])
                  a.wake = 1'b1;
            end
            if (a.wake)
               shadow_waiting[r.vidx] = 1'b0;
         end
      endcase
      a.readers = shadow_readers[r.vidx];
      a.writer  = shadow_writer[r.vidx];
      return a;
   endfunction

   function automatic void queue_req(logic [rwlt_pkg::KIND_W-1:0] k, int t, int v);
      lock_req_type r;
      r.kind = k;
      r.txn  = t[rwlt_pkg::ID_W-1:0];
      r.vidx = v[rwlt_pkg::ID_W-1:0];
      pending_reqs = {pending_reqs, r};
   endfunction

   // idle percentage per side, by how far the run has got
   function automatic int idle_pct(bit sender_side);
      if (sent_count < total_items / 3)
         return sender_side ? 13 : 48;
      if (sent_count < 2 * total_items / 3)
         return sender_side ? 48 : 13;
      return 0;
   endfunction

   // request driver; the shadow table steps on every accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            lock_answers_q = {lock_answers_q,
                              apply_lock_request('{req_kind, req_txn_id, req_var_index})};
            sent_count <= sent_count + 1;
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
               req_valid     <= 1'b1;
               req_kind      <= pending_reqs[0].kind;
               req_txn_id    <= pending_reqs[0].txn;
               req_var_index <= pending_reqs[0].vidx;
               void'(pending_reqs.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-offs so the block backs up into its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left == 0 && sent_count >= next_hold_at) begin
         hold_left    <= HOLD_LEN;
         next_hold_at <= next_hold_at + 650;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // response stall
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= (hold_left != 0) || ($urandom_range(99) < idle_pct(1'b0));
   end

   // response monitor
   always @(posedge clock) begin
      lock_answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (lock_answers_q.size() == 0) begin
            $error("response with no request outstanding: outcome %0d", rsp_outcome);
            error_count++;
         end else begin
            want = lock_answers_q.pop_front();
            n_checked++;
            if (rsp_outcome !== want.outcome) begin
               $error("outcome: expected %0d, got %0d", want.outcome, rsp_outcome);
               error_count++;
            end
            if (rsp_wake_waiters !== want.wake) begin
               $error("wake_waiters: expected %0d, got %0d", want.wake, rsp_wake_waiters);
               error_count++;
            end
            if (rsp_readers_now !== want.readers) begin
               $error("readers_now: expected %0d, got %0d", want.readers, rsp_readers_now);
               error_count++;
            end
            if (rsp_writer_held !== want.writer) begin
               $error("writer_held: expected %0d, got %0d", want.writer, rsp_writer_held);
               error_count++;
            end
            case (want.outcome)
               rwlt_pkg::OUT_OK:   n_granted++;
               rwlt_pkg::OUT_WAIT: n_waits++;
               default:            n_refused++;
            endcase
            if (want.wake)
               n_wakes++;
            if (int'(want.readers) > peak_readers)
               peak_readers = int'(want.readers);
         end
      end
   end

   // stimulus, reset and end of run
   initial begin
      int ids[N_TXNS];
      int n_dir;
      int pick;
      int t;
      int u;
      int v;
      int n;
      int j;
      int tmp;

      for (int i = 0; i < N_VARS; i++) begin
         shadow_readers[i] = '0;
         shadow_writer[i]  = 1'b0;
         shadow_waiting[i] = 1'b0;
      end
      for (int i = 0; i < N_TXNS * N_VARS; i++)
         shadow_mode[i] = rwlt_pkg::MODE_NONE;

      // directed: sharing, own-lock cases, upgrade paths, wakeups
      queue_req(rwlt_pkg::KIND_READ, 0, 0);
      queue_req(rwlt_pkg::KIND_READ, 0, 0);       // read while holding read
      queue_req(rwlt_pkg::KIND_WRITE, 1, 0);      // blocked by readers
      queue_req(rwlt_pkg::KIND_WRITE, 0, 0);      // blocked by own read lock
      queue_req(rwlt_pkg::KIND_UPGRADE, 2, 0);    // nothing held, refused
      queue_req(rwlt_pkg::KIND_READ, 15, 0);
      queue_req(rwlt_pkg::KIND_UPGRADE, 0, 0);    // two readers, waits
      queue_req(rwlt_pkg::KIND_RELEASE, 15, 0);   // readers left, no wake
      queue_req(rwlt_pkg::KIND_UPGRADE, 0, 0);    // sole reader upgrades
      queue_req(rwlt_pkg::KIND_READ, 0, 0);       // read while holding write
      queue_req(rwlt_pkg::KIND_WRITE, 0, 0);      // write while holding write
      queue_req(rwlt_pkg::KIND_READ, 3, 0);       // blocked by writer
      queue_req(rwlt_pkg::KIND_RELEASE, 0, 0);    // writer release wakes
      queue_req(rwlt_pkg::KIND_RELEASE, 0, 0);    // release with nothing held
      queue_req(rwlt_pkg::KIND_WRITE, 15, 15);
      queue_req(rwlt_pkg::KIND_RELEASE, 15, 15);
      queue_req(rwlt_pkg::KIND_READ, 5, 15);
      queue_req(rwlt_pkg::KIND_WRITE, 6, 15);
      queue_req(rwlt_pkg::KIND_RELEASE, 5, 15);   // last reader out with writer waiting
      queue_req(rwlt_pkg::KIND_RELEASE, 6, 15);
      queue_req(rwlt_pkg::KIND_WRITE, 7, 9);
      queue_req(rwlt_pkg::KIND_UPGRADE, 7, 9);    // holding write, refused
      queue_req(rwlt_pkg::KIND_RELEASE, 7, 9);
      n_dir = pending_reqs.size();

      // random lock sequences with random content, plus some noise
      while (pending_reqs.size() < n_dir + RAND_ITEMS) begin
         pick = $urandom_range(99);
         t = $urandom_range(N_TXNS - 1);
         u = (t + $urandom_range(1, N_TXNS - 1)) % N_TXNS;
         v = $urandom_range(N_VARS - 1);
         if (pick < 15) begin
            // crowd of readers, optional upgrade attempt, releases in random order
            for (int i = 0; i < N_TXNS; i++)
               ids[i] = i;
            for (int i = N_TXNS - 1; i > 0; i--) begin
               j = $urandom_range(i);
               tmp = ids[i]; ids[i] = ids[j]; ids[j] = tmp;
            end
            n = $urandom_range(2, N_TXNS);
            for (int i = 0; i < n; i++)
               queue_req(rwlt_pkg::KIND_READ, ids[i], v);
            if ($urandom_range(1))
               queue_req(rwlt_pkg::KIND_UPGRADE, ids[0], v);
            for (int i = n - 1; i > 0; i--) begin
               j = $urandom_range(i);
               tmp = ids[i]; ids[i] = ids[j]; ids[j] = tmp;
            end
            for (int i = 0; i < n; i++)
               queue_req(rwlt_pkg::KIND_RELEASE, ids[i], v);
         end else if (pick < 45) begin
            // read then upgrade, sometimes against a second reader
            queue_req(rwlt_pkg::KIND_READ, t, v);
            if ($urandom_range(1)) begin
               queue_req(rwlt_pkg::KIND_READ, u, v);
               queue_req(rwlt_pkg::KIND_UPGRADE, t, v);
               queue_req(rwlt_pkg::KIND_RELEASE, u, v);
            end
            queue_req(rwlt_pkg::KIND_UPGRADE, t, v);
            queue_req(rwlt_pkg::KIND_WRITE, u, v);
            queue_req(rwlt_pkg::KIND_RELEASE, t, v);
            queue_req(rwlt_pkg::KIND_WRITE, u, v);
            queue_req(rwlt_pkg::KIND_RELEASE, u, v);
         end else if (pick < 75) begin
            // writer blocks a reader, release wakes it
            queue_req(rwlt_pkg::KIND_WRITE, t, v);
            queue_req(rwlt_pkg::KIND_READ, u, v);
            queue_req(rwlt_pkg::KIND_UPGRADE, u, v);
            queue_req(rwlt_pkg::KIND_RELEASE, t, v);
            queue_req(rwlt_pkg::KIND_READ, u, v);
            queue_req(rwlt_pkg::KIND_RELEASE, u, v);
         end else begin
            // noise, half of it on the hot variables 0 to 3
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
               queue_req(rwlt_pkg::KIND_W'($urandom_range(3)), $urandom_range(N_TXNS - 1),
                         $urandom_range(1) ? $urandom_range(3) : $urandom_range(N_VARS - 1));
         end
      end
      total_items = pending_reqs.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_valid)
         @(posedge clock);
      while (lock_answers_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("checked %0d lock transactions: %0d granted, %0d told to wait, %0d refused",
               n_checked, n_granted, n_waits, n_refused);
      $display("%0d wakeups signalled, peak reader count %0d, two long response hold-offs",
               n_wakes, peak_readers);
      if (error_count == 0 && lock_answers_q.size() == 0)
         $display("reader_writer_lock_table_unit_tb: PASS");
      else
         $display("reader_writer_lock_table_unit_tb: FAIL");
      $finish;
   end

   // watchdog
   initial begin
      #8000000;
      $display("timeout waiting for the lock table to drain");
      $display("reader_writer_lock_table_unit_tb: FAIL");
      $finish;
   end

endmodule

### reader_writer_lock_table_unit.f
design/rwlt_pkg.sv
design/rwlt_ram.sv
design/rwlt_decide.sv
design/reader_writer_lock_table_unit.sv
design/rwlt_checker.sv
dv/reader_writer_lock_table_unit_tb.sv
